### rtl/assert_macros.svh
// Assertion helpers, clocked on clk and held off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define ASSERT_NEVER(label, expr, msg) \
	`ASSERT_CLK(label, !(expr), msg)

`endif

### rtl/mnes_pkg.sv
`default_nettype none
package mnes_pkg;

	localparam int SLOT_REGS   = 8;
	localparam int SLOT_W      = 37;
	localparam int SLOT_IDX_W  = 3;
	localparam int ADDR_W      = 6;
	localparam int MSG_W       = 22;
	localparam int MAX_RESULTS = 32;
	localparam int RES_W       = 6;
	localparam int BUF_IDX_W   = 5;

	// floor(p / 100) == (p * DIV_K) >> DIV_S for every 19-bit product p
	localparam int DIV_S = 32;
	localparam logic [25:0] DIV_K = 26'd42949673;
	localparam int DIV_PCT = 100;

	localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
	localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
	localparam logic [3:0] KIND_AFTER    = 4'hA;
	localparam logic [3:0] KIND_BEND     = 4'hE;

	localparam logic [6:0] DATA_MAX = 7'd127;

	typedef struct packed {
		logic latch_in;
		logic slot_first;
		logic slot_next;
		logic calc_p;
		logic calc_v;
		logic emit_echo;
		logic ptr_clr;
		logic ptr_next;
		logic place;
		logic set_drop;
		logic mem_rd;
		logic tick_upd;
		logic pass;
		logic drain_clr;
		logic drain_next;
		logic buf_rd;
	} cmd_t;

	typedef struct packed {
		logic is_tick;
		logic is_note;
		logic is_pass;
		logic slot_en;
		logic slot_last;
		logic delay_zero;
		logic ptr_end;
		logic ptr_free;
		logic ptr_last;
		logic nres_zero;
		logic drain_last;
	} sts_t;

endpackage
`default_nettype wire

### rtl/mnes_regs.sv
`default_nettype none
module mnes_regs (
	input  wire logic                                           clk,
	input  wire logic                                           arst_n,
	input  wire logic                                           psel,
	input  wire logic                                           penable,
	input  wire logic                                           pwrite,
	input  wire logic [mnes_pkg::ADDR_W-1:0]                    paddr,
	input  wire logic [63:0]                                    pwdata,
	output logic [63:0]                                         prdata,
	output logic                                                pready,
	output logic [mnes_pkg::SLOT_REGS-1:0][mnes_pkg::SLOT_W-1:0] slots
);

	logic [mnes_pkg::SLOT_REGS-1:0][mnes_pkg::SLOT_W-1:0] slot_q;
	logic [mnes_pkg::SLOT_IDX_W-1:0] idx;

	assign idx    = paddr[mnes_pkg::ADDR_W-1:3];
	assign pready = 1'b1;
	assign prdata = {{(64-mnes_pkg::SLOT_W){1'b0}}, slot_q[idx]};
	assign slots  = slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			slot_q[idx] <= pwdata[mnes_pkg::SLOT_W-1:0];
		end
	end

endmodule
`default_nettype wire

### rtl/mnes_dp.sv
`default_nettype none
module mnes_dp #(
	parameter int NUM_ECHO_SLOTS = 8,
	parameter int PENDING_DEPTH  = 32
) (
	input  wire logic                                            clk,
	input  wire logic                                            arst_n,
	input  wire mnes_pkg::cmd_t                                  cmd,
	output mnes_pkg::sts_t                                       sts,
	input  wire logic [mnes_pkg::SLOT_REGS-1:0][mnes_pkg::SLOT_W-1:0] slots,
	input  wire logic                                            in_func,
	input  wire logic [mnes_pkg::MSG_W-1:0]                      in_msg,
	output logic [mnes_pkg::MSG_W-1:0]                           out_msg,
	output logic                                                 out_last,
	output logic                                                 out_drop
);

	localparam int PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int CW = $clog2(PENDING_DEPTH + 1);

	logic                        func_q;
	logic [mnes_pkg::MSG_W-1:0]  msg_q;
	logic [mnes_pkg::SLOT_IDX_W-1:0] slot_q;
	logic [CW-1:0]               ptr_q;
	logic [mnes_pkg::RES_W-1:0]  nres_q;
	logic [mnes_pkg::BUF_IDX_W-1:0] didx_q;
	logic                        drop_q;
	logic [PENDING_DEPTH-1:0]    valid_q;

	logic [18:0] prod_q;
	logic [6:0]  note_q;
	logic [6:0]  vel_q;
	logic [15:0] delay_q;
	logic [15:0] rd_rem_q;
	logic [mnes_pkg::MSG_W-1:0] rd_msg_q;

	logic [15:0]                rem_mem [PENDING_DEPTH];
	logic [mnes_pkg::MSG_W-1:0] msg_mem [PENDING_DEPTH];
	logic [mnes_pkg::MSG_W-1:0] buf_mem [mnes_pkg::MAX_RESULTS];

	logic [mnes_pkg::SLOT_W-1:0] slot_r;
	logic [PW-1:0]  pidx;
	logic [3:0]     kind;
	logic signed [8:0] note_sum;
	logic [44:0]    quot_full;
	logic [12:0]    quot;
	logic [mnes_pkg::MSG_W-1:0] echo_msg;
	logic           res_room;
	logic           due;
	logic           mem_we;
	logic [15:0]    mem_wrem;
	logic [mnes_pkg::MSG_W-1:0] mem_wmsg;
	logic           buf_we;
	logic [mnes_pkg::MSG_W-1:0] buf_wdata;

	assign slot_r   = slots[slot_q];
	assign pidx     = ptr_q[PW-1:0];
	assign kind     = msg_q[7:4];
	assign echo_msg = {vel_q, note_q, msg_q[7:0]};
	assign res_room = nres_q < mnes_pkg::RES_W'(mnes_pkg::MAX_RESULTS);
	assign due      = rd_rem_q <= 16'd1;
	assign note_sum = $signed({2'b00, msg_q[14:8]}) + $signed({slot_r[23], slot_r[23:16]});
	assign quot_full = 45'(prod_q) * 45'(mnes_pkg::DIV_K);
	assign quot      = quot_full[mnes_pkg::DIV_S +: 13];

	always_comb begin
		sts.is_tick    = func_q;
		sts.is_note    = !func_q && (kind == mnes_pkg::KIND_NOTE_OFF ||
			kind == mnes_pkg::KIND_NOTE_ON);
		sts.is_pass    = !func_q && kind >= mnes_pkg::KIND_AFTER &&
			kind <= mnes_pkg::KIND_BEND;
		sts.slot_en    = slot_r[36] &&
			(32'(slot_q) < NUM_ECHO_SLOTS);
		sts.slot_last  = slot_q == mnes_pkg::SLOT_IDX_W'(NUM_ECHO_SLOTS - 1);
		sts.delay_zero = delay_q == 16'd0;
		sts.ptr_end    = ptr_q == CW'(PENDING_DEPTH);
		sts.ptr_free   = !valid_q[pidx];
		sts.ptr_last   = ptr_q == CW'(PENDING_DEPTH - 1);
		sts.nres_zero  = nres_q == '0;
		sts.drain_last = {1'b0, didx_q} == nres_q - mnes_pkg::RES_W'(1);
	end

	// one write port on the pending store: placement or tick countdown
	always_comb begin
		mem_we   = 1'b0;
		mem_wrem = rd_rem_q - 16'd1;
		mem_wmsg = rd_msg_q;
		if (cmd.place) begin
			mem_we   = 1'b1;
			mem_wrem = delay_q;
			mem_wmsg = echo_msg;
		end else if (cmd.tick_upd && valid_q[pidx]) begin
			mem_we = 1'b1;
			if (due) begin
				mem_wrem = 16'd1;
			end
		end
	end

	always_comb begin
		buf_we    = 1'b0;
		buf_wdata = echo_msg;
		if (cmd.emit_echo && res_room) begin
			buf_we = 1'b1;
		end else if (cmd.pass) begin
			buf_we    = 1'b1;
			buf_wdata = msg_q;
		end else if (cmd.tick_upd && valid_q[pidx] && due && res_room) begin
			buf_we    = 1'b1;
			buf_wdata = rd_msg_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			ptr_q   <= '0;
			nres_q  <= '0;
			didx_q  <= '0;
			drop_q  <= 1'b0;
			valid_q <= '0;
		end else begin
			if (cmd.latch_in) begin
				nres_q <= '0;
			end else if (buf_we) begin
				nres_q <= nres_q + mnes_pkg::RES_W'(1);
			end
			if (cmd.slot_first) begin
				slot_q <= '0;
			end else if (cmd.slot_next) begin
				slot_q <= slot_q + mnes_pkg::SLOT_IDX_W'(1);
			end
			if (cmd.ptr_clr) begin
				ptr_q <= '0;
			end else if (cmd.ptr_next) begin
				ptr_q <= ptr_q + CW'(1);
			end
			if (cmd.drain_clr) begin
				didx_q <= '0;
			end else if (cmd.drain_next) begin
				didx_q <= didx_q + mnes_pkg::BUF_IDX_W'(1);
			end
			if (cmd.set_drop) begin
				drop_q <= 1'b1;
			end
			if (cmd.place) begin
				valid_q[pidx] <= 1'b1;
			end else if (cmd.tick_upd && valid_q[pidx] && due && res_room) begin
				valid_q[pidx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			func_q <= in_func;
			msg_q  <= in_msg;
		end
		if (cmd.calc_p) begin
			prod_q  <= 19'(msg_q[21:15]) * 19'(slot_r[35:24]);
			delay_q <= slot_r[15:0];
			if (note_sum < 0) begin
				note_q <= 7'd0;
			end else if (note_sum > 9'sd127) begin
				note_q <= mnes_pkg::DATA_MAX;
			end else begin
				note_q <= note_sum[6:0];
			end
		end
		if (cmd.calc_v) begin
			vel_q <= (quot > 13'(mnes_pkg::DATA_MAX)) ? mnes_pkg::DATA_MAX : quot[6:0];
		end
		if (cmd.buf_rd) begin
			out_msg  <= buf_mem[didx_q];
			out_last <= sts.drain_last;
			out_drop <= drop_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_rd) begin
			rd_rem_q <= rem_mem[pidx];
			rd_msg_q <= msg_mem[pidx];
		end
		if (mem_we) begin
			rem_mem[pidx] <= mem_wrem;
			msg_mem[pidx] <= mem_wmsg;
		end
	end

	always_ff @(posedge clk) begin
		if (buf_we) begin
			buf_mem[nres_q[mnes_pkg::BUF_IDX_W-1:0]] <= buf_wdata;
		end
	end

endmodule
`default_nettype wire

### rtl/mnes_ctrl.sv
`default_nettype none
module mnes_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  wire mnes_pkg::sts_t sts,
	output mnes_pkg::cmd_t      cmd
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_DISP, ST_SCHK, ST_SP, ST_SV, ST_SACT, ST_FCHK, ST_SNEXT,
		ST_TRD, ST_TUPD, ST_FIN, ST_DRD, ST_DWAIT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign accept = in_valid && in_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.latch_in = 1'b1;
					state_d      = ST_DISP;
				end
			end
			ST_DISP: begin
				cmd.slot_first = 1'b1;
				cmd.ptr_clr    = 1'b1;
				priority if (sts.is_tick) begin
					state_d = ST_TRD;
				end else if (sts.is_note) begin
					state_d = ST_SCHK;
				end else if (sts.is_pass) begin
					cmd.pass = 1'b1;
					state_d  = ST_FIN;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SCHK: begin
				state_d = sts.slot_en ? ST_SP : ST_SNEXT;
			end
			ST_SP: begin
				cmd.calc_p = 1'b1;
				state_d    = ST_SV;
			end
			ST_SV: begin
				cmd.calc_v = 1'b1;
				state_d    = ST_SACT;
			end
			ST_SACT: begin
				if (sts.delay_zero) begin
					cmd.emit_echo = 1'b1;
					state_d       = ST_SNEXT;
				end else begin
					state_d = ST_FCHK;
				end
			end
			ST_FCHK: begin
				// free entries are taken in index order, so the search resumes where it stopped
				priority if (sts.ptr_end) begin
					cmd.set_drop = 1'b1;
					state_d      = ST_SNEXT;
				end else if (sts.ptr_free) begin
					cmd.place    = 1'b1;
					cmd.ptr_next = 1'b1;
					state_d      = ST_SNEXT;
				end else begin
					cmd.ptr_next = 1'b1;
				end
			end
			ST_SNEXT: begin
				if (sts.slot_last) begin
					state_d = ST_FIN;
				end else begin
					cmd.slot_next = 1'b1;
					state_d       = ST_SCHK;
				end
			end
			ST_TRD: begin
				cmd.mem_rd = 1'b1;
				state_d    = ST_TUPD;
			end
			ST_TUPD: begin
				cmd.tick_upd = 1'b1;
				if (sts.ptr_last) begin
					state_d = ST_FIN;
				end else begin
					cmd.ptr_next = 1'b1;
					state_d      = ST_TRD;
				end
			end
			ST_FIN: begin
				if (sts.nres_zero) begin
					state_d = ST_IDLE;
				end else begin
					cmd.drain_clr = 1'b1;
					state_d       = ST_DRD;
				end
			end
			ST_DRD: begin
				cmd.buf_rd = 1'b1;
				state_d    = ST_DWAIT;
			end
			ST_DWAIT: begin
				if (out_ready) begin
					if (sts.drain_last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.drain_next = 1'b1;
						state_d        = ST_DRD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			in_ready  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q   <= state_d;
			in_ready  <= state_d == ST_IDLE;
			out_valid <= state_d == ST_DWAIT;
		end
	end

endmodule
`default_nettype wire

### rtl/midi_note_echo_scheduler.sv
// MIDI note echo scheduler.
// Input stream: s_axis_tuser = 1 is a one millisecond tick, 0 a MIDI channel
// message in s_axis_tdata. Output stream: one emitted message per request,
// m_axis_tlast on the final result of an input, m_axis_tuser the sticky
// "echo dropped" flag as it stands after that input.
// Echo slots are 37-bit registers on the APB port at byte address 8*i.
// Items are handled one at a time; s_axis_tready is high only when idle.
// Note message: decode, then per slot a check of its enable; an enabled slot
// computes the echo note, then its velocity, and its echo then goes out at
// once or is placed by a lowest-free search of the pending store (the search
// pointer only moves forward within a note, so all slots together step over
// at most PENDING_DEPTH entries). Tick: one registered read of the pending
// store and one update per entry. Then the results are drained from the
// result buffer; a stalled m_axis_tready holds the current result and the
// block takes no new input until the last result is taken.
// Reset empties the pending store at once (per-entry valid bits), clears
// the slots and the dropped flag; no clearing pass is needed.
`default_nettype none
module midi_note_echo_scheduler #(
	parameter int NUM_ECHO_SLOTS = 8,
	parameter int PENDING_DEPTH  = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire logic [23:0]                 s_axis_tdata, // status_byte, first_data, second_data
	input  wire logic                        s_axis_tuser, // func
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	output logic [23:0]                      m_axis_tdata, // out_status, out_first, out_second
	output logic                             m_axis_tlast,
	output logic                             m_axis_tuser, // echoes_dropped
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [mnes_pkg::ADDR_W-1:0] paddr,
	input  wire logic [63:0]                 pwdata,
	output logic [63:0]                      prdata,
	output logic                             pready
);

	logic [mnes_pkg::SLOT_REGS-1:0][mnes_pkg::SLOT_W-1:0] slots;
	mnes_pkg::cmd_t cmd;
	mnes_pkg::sts_t sts;
	logic [mnes_pkg::MSG_W-1:0] out_msg;

	assign m_axis_tdata = {2'b00, out_msg};

	mnes_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.slots  (slots)
	);

	mnes_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mnes_dp #(
		.NUM_ECHO_SLOTS(NUM_ECHO_SLOTS),
		.PENDING_DEPTH (PENDING_DEPTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.slots   (slots),
		.in_func (s_axis_tuser),
		.in_msg  (s_axis_tdata[mnes_pkg::MSG_W-1:0]),
		.out_msg (out_msg),
		.out_last(m_axis_tlast),
		.out_drop(m_axis_tuser)
	);

endmodule
`default_nettype wire

### rtl/mnes_checker.sv
`default_nettype none
`include "assert_macros.svh"
module mnes_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [23:0] m_axis_tdata,
	input wire logic        m_axis_tlast,
	input wire logic        m_axis_tuser
);

	// hold a stalled result
	`ASSERT_CLK(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "stalled result changed")
	// one item at a time: no input taken while a result is offered
	`ASSERT_NEVER(a_no_overlap, s_axis_tready && m_axis_tvalid, "input ready while result pending")
	`ASSERT_CLK(a_busy_after_accept, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "ready stayed high after accept")
	`ASSERT_CLK(a_last_ends_run, m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid, "result after last of run")

endmodule

bind midi_note_echo_scheduler mnes_checker u_mnes_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tlast (m_axis_tlast),
	.m_axis_tuser (m_axis_tuser)
);
`default_nettype wire
